// ===== design/ssbs_pkg.sv =====
// Shared types and constants of the supply switch and button supervisor.
// No dependencies; every other design file depends on this package.
package ssbs_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int COUNT_W     = 16;
    localparam int STABLE_W    = 8;

    // Opcodes of an input beat
    localparam logic [1:0] OP_TICK         = 2'd0;
    localparam logic [1:0] OP_SUPPLY_DROP  = 2'd1;
    localparam logic [1:0] OP_CHARGE_DELAY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SUPPLY_LEVEL     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_LEVEL     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SUPPLY_QUALIFY   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BOUNCE_TICKS     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POWER_DOWN_TICKS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WIPE_TICKS       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARGE_ALLOWED   = 3'd6;

    // Register reset values
    localparam int SUPPLY_LEVEL_RST = 2048;
    localparam int BUTTON_LEVEL_RST = 2730;
    localparam logic [COUNT_W-1:0]  SUPPLY_QUALIFY_RST = 16'd20;
    localparam logic [STABLE_W-1:0] BOUNCE_TICKS_RST   = 8'd3;
    localparam logic [COUNT_W-1:0]  POWER_DOWN_RST     = 16'd400;   // 200 * 2
    localparam logic [COUNT_W-1:0]  WIPE_RST           = 16'd2000;  // 200 * 10

    // Sample-independent configuration, plus the qualifier clear strobe
    typedef struct packed {
        logic [COUNT_W-1:0]  supply_qualify_ticks;
        logic [STABLE_W-1:0] bounce_ticks;
        logic [COUNT_W-1:0]  power_down_ticks;
        logic [COUNT_W-1:0]  wipe_ticks;
        logic                charge_allowed;
        logic                clear_supply_count;
    } cfg_t;

    typedef struct packed {
        logic on_battery;
        logic switched_to_external;
        logic charger_released;
        logic button_down;
        logic lights_off;
        logic power_stop;
        logic wipe_reset;
    } res_t;

endpackage

// ===== design/ssbs_if.sv =====
// Valid/ready channel interfaces for input beats and result beats.
// Depends on ssbs_pkg for the default sample width.
interface ssbs_item_if #(parameter int SAMPLE_BITS = ssbs_pkg::SAMPLE_BITS_DEF);
    logic                   valid;
    logic                   ready;
    logic [1:0]             opcode;
    logic [SAMPLE_BITS-1:0] supply_sample;
    logic [SAMPLE_BITS-1:0] button_sample;

    modport source (output valid, output opcode, output supply_sample,
                    output button_sample, input ready);
    modport sink   (input valid, input opcode, input supply_sample,
                    input button_sample, output ready);
endinterface

interface ssbs_result_if;
    logic valid;
    logic ready;
    logic on_battery;
    logic switched_to_external;
    logic charger_released;
    logic button_down;
    logic lights_off;
    logic power_stop;
    logic wipe_reset;

    modport source (output valid, output on_battery, output switched_to_external,
                    output charger_released, output button_down,
                    output lights_off, output power_stop, output wipe_reset,
                    input ready);
    modport sink   (input valid, input on_battery, input switched_to_external,
                    input charger_released, input button_down,
                    input lights_off, input power_stop, input wipe_reset,
                    output ready);
endinterface

// ===== design/ssbs_cfg_regs.sv =====
// Configuration register file: plain write port, no read-back.
// Depends on ssbs_pkg.
module ssbs_cfg_regs #(
    parameter int SAMPLE_BITS = ssbs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ssbs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ssbs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [SAMPLE_BITS-1:0]              supply_level,
    output logic [SAMPLE_BITS-1:0]              button_level,
    output ssbs_pkg::cfg_t                      cfg
);
    import ssbs_pkg::*;

    logic [SAMPLE_BITS-1:0] supply_level_reg;
    logic [SAMPLE_BITS-1:0] button_level_reg;
    logic [COUNT_W-1:0]     qualify_reg;
    logic [STABLE_W-1:0]    bounce_reg;
    logic [COUNT_W-1:0]     power_down_reg;
    logic [COUNT_W-1:0]     wipe_reg;
    logic                   charge_allowed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_level_reg   <= SAMPLE_BITS'(SUPPLY_LEVEL_RST);
            button_level_reg   <= SAMPLE_BITS'(BUTTON_LEVEL_RST);
            qualify_reg        <= SUPPLY_QUALIFY_RST;
            bounce_reg         <= BOUNCE_TICKS_RST;
            power_down_reg     <= POWER_DOWN_RST;
            wipe_reg           <= WIPE_RST;
            charge_allowed_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SUPPLY_LEVEL:     supply_level_reg   <= cfg_data[SAMPLE_BITS-1:0];
                REG_BUTTON_LEVEL:     button_level_reg   <= cfg_data[SAMPLE_BITS-1:0];
                REG_SUPPLY_QUALIFY:   qualify_reg        <= cfg_data;
                REG_BOUNCE_TICKS:     bounce_reg         <= cfg_data[STABLE_W-1:0];
                REG_POWER_DOWN_TICKS: power_down_reg     <= cfg_data;
                REG_WIPE_TICKS:       wipe_reg           <= cfg_data;
                REG_CHARGE_ALLOWED:   charge_allowed_reg <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    assign supply_level = supply_level_reg;
    assign button_level = button_level_reg;

    always_comb
    begin
        cfg.supply_qualify_ticks = qualify_reg;
        cfg.bounce_ticks         = bounce_reg;
        cfg.power_down_ticks     = power_down_reg;
        cfg.wipe_ticks           = wipe_reg;
        cfg.charge_allowed       = charge_allowed_reg;
        // writing charge_allowed also restarts supply qualification
        cfg.clear_supply_count   = cfg_we && (cfg_index == REG_CHARGE_ALLOWED);
    end

endmodule

// ===== design/ssbs_supervise.sv =====
// Supervisor state and its single-pass update for one beat.
// Depends on ssbs_pkg; fed by the input register in the top level.
module ssbs_supervise #(
    parameter int SAMPLE_BITS = ssbs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [1:0]             opcode,
    input  logic [SAMPLE_BITS-1:0] supply_sample,
    input  logic [SAMPLE_BITS-1:0] button_sample,
    input  logic [SAMPLE_BITS-1:0] supply_level,
    input  logic [SAMPLE_BITS-1:0] button_level,
    input  ssbs_pkg::cfg_t         cfg,
    output ssbs_pkg::res_t         res
);
    import ssbs_pkg::*;

    logic                last_present_reg, last_present_next;
    logic [COUNT_W-1:0]  supply_count_reg, supply_count_next;
    logic                battery_reg, battery_next;
    logic                charger_reg, charger_next;
    logic                raw_button_reg, raw_button_next;
    logic [STABLE_W-1:0] stable_reg, stable_next;
    logic                debounced_reg, debounced_next;
    logic [COUNT_W-1:0]  hold_reg, hold_next;

    logic                present;
    logic                pressed_now;
    logic                qualified;
    logic [COUNT_W-1:0]  count_tick;

    always_comb
    begin
        present     = (supply_sample >= supply_level);
        pressed_now = (button_sample >= button_level);

        last_present_next = last_present_reg;
        supply_count_next = supply_count_reg;
        battery_next      = battery_reg;
        charger_next      = charger_reg;
        raw_button_next   = raw_button_reg;
        stable_next       = stable_reg;
        debounced_next    = debounced_reg;
        hold_next         = hold_reg;

        count_tick = '0;
        if (present && last_present_reg)
            count_tick = (supply_count_reg == '1) ? supply_count_reg
                                                  : supply_count_reg + 1'b1;
        qualified = (count_tick >= cfg.supply_qualify_ticks);

        res = '0;

        case (opcode)
            OP_TICK:
            begin
                supply_count_next = count_tick;
                last_present_next = present;

                if (qualified)
                begin
                    battery_next             = 1'b0;
                    res.switched_to_external = battery_reg;
                end
                if (cfg.charge_allowed)
                    charger_next = qualified;

                if (raw_button_reg != pressed_now)
                begin
                    raw_button_next = pressed_now;
                    stable_next     = '0;
                end
                else
                begin
                    stable_next = (stable_reg == '1) ? stable_reg : stable_reg + 1'b1;
                    if (stable_next > cfg.bounce_ticks)
                        debounced_next = raw_button_reg;
                end

                if (debounced_next)
                begin
                    if (hold_reg < cfg.power_down_ticks)
                        hold_next = hold_reg + 1'b1;
                    else if (hold_reg < cfg.wipe_ticks)
                    begin
                        res.lights_off = 1'b1;
                        hold_next      = hold_reg + 1'b1;
                    end
                    else
                        res.wipe_reset = 1'b1;
                end
                else if (hold_reg >= cfg.power_down_ticks)
                    res.power_stop = 1'b1;   // hold count kept: repeats until pressed again
                else
                    hold_next = '0;
            end
            OP_SUPPLY_DROP:  battery_next      = 1'b1;
            OP_CHARGE_DELAY: supply_count_next = '0;
            default:         ;
        endcase

        res.on_battery       = battery_next;
        res.charger_released = charger_next;
        res.button_down      = debounced_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_present_reg <= 1'b0;
            supply_count_reg <= '0;
            battery_reg      <= 1'b1;
            charger_reg      <= 1'b0;
            raw_button_reg   <= 1'b0;
            stable_reg       <= '0;
            debounced_reg    <= 1'b0;
            hold_reg         <= '0;
        end
        else if (cfg.clear_supply_count)
        begin
            supply_count_reg <= '0;
        end
        else if (step)
        begin
            last_present_reg <= last_present_next;
            supply_count_reg <= supply_count_next;
            battery_reg      <= battery_next;
            charger_reg      <= charger_next;
            raw_button_reg   <= raw_button_next;
            stable_reg       <= stable_next;
            debounced_reg    <= debounced_next;
            hold_reg         <= hold_next;
        end
    end

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.clear_supply_count |=> (supply_count_reg == '0))
        else $error("supply count not cleared by charge_allowed write");

    a_hold_frozen_released: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.power_stop) |=> (hold_reg == $past(hold_reg)))
        else $error("hold count moved during power stop request");

endmodule

// ===== design/supply_switch_and_button_supervisor_core.sv =====
// Top level of the supply switch and button supervisor.
// Depends on ssbs_pkg, ssbs_if, ssbs_cfg_regs and ssbs_supervise.
//
//  port      dir   handshake       beat contents
//  item      sink  valid/ready     opcode, supply_sample, button_sample
//  result    src   valid/ready     on_battery .. wipe_reset (7 flags)
//  cfg_*     in    cfg_we only     cfg_index, cfg_data (16 bits)
//
// One beat per clock while the result is not stalled; a beat passes the input
// register, then the state update and result register in the same cycle.
// rst_n resets all supervisor state and loads the register defaults.
// A stalled result holds the result register; the input register still
// takes one more beat, after which item.ready follows result.ready.
module supply_switch_and_button_supervisor_core #(
    parameter int SAMPLE_BITS = ssbs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ssbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ssbs_pkg::CFG_DATA_W-1:0]   cfg_data,
    ssbs_item_if.sink                         item,
    ssbs_result_if.source                     result
);
    import ssbs_pkg::*;

    logic [SAMPLE_BITS-1:0] supply_level;
    logic [SAMPLE_BITS-1:0] button_level;
    cfg_t                   cfg;

    logic                   s1_valid_reg, s1_valid_next;
    logic [1:0]             s1_opcode_reg;
    logic [SAMPLE_BITS-1:0] s1_supply_reg;
    logic [SAMPLE_BITS-1:0] s1_button_reg;

    logic                   res_valid_reg, res_valid_next;
    res_t                   res_reg;
    res_t                   res_comb;

    logic                   res_load;
    logic                   advance;
    logic                   take;

    ssbs_cfg_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .supply_level (supply_level),
        .button_level (button_level),
        .cfg          (cfg)
    );

    ssbs_supervise #(.SAMPLE_BITS(SAMPLE_BITS)) u_supervise (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .opcode        (s1_opcode_reg),
        .supply_sample (s1_supply_reg),
        .button_sample (s1_button_reg),
        .supply_level  (supply_level),
        .button_level  (button_level),
        .cfg           (cfg),
        .res           (res_comb)
    );

    assign res_load   = !res_valid_reg || result.ready;
    assign advance    = s1_valid_reg && res_load;
    assign item.ready = !s1_valid_reg || res_load;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        res_valid_next = res_load ? s1_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_opcode_reg <= item.opcode;
            s1_supply_reg <= item.supply_sample;
            s1_button_reg <= item.button_sample;
        end
        if (advance)
            res_reg <= res_comb;
    end

    assign result.valid                = res_valid_reg;
    assign result.on_battery           = res_reg.on_battery;
    assign result.switched_to_external = res_reg.switched_to_external;
    assign result.charger_released     = res_reg.charger_released;
    assign result.button_down          = res_reg.button_down;
    assign result.lights_off           = res_reg.lights_off;
    assign result.power_stop           = res_reg.power_stop;
    assign result.wipe_reset           = res_reg.wipe_reset;

    a_switch_leaves_battery: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.switched_to_external && result.on_battery))
        else $error("switch to external reported while still on battery");

    a_lights_wipe_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.lights_off && result.wipe_reset))
        else $error("lights_off and wipe_reset in one beat");

    a_stop_needs_release: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.power_stop |-> !result.button_down)
        else $error("power_stop while button still pressed");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_opcode_reg)))
        else $error("input register lost a waiting beat");

endmodule
